>>> design/dcsb_pkg.sv
// ----------------------------------------------------------------------------
// dcsb_pkg: shared types and constants of the double-click SOS beacon
// Mode codes, register map, reset values and the structs passed between
// the top level and the per-tick step logic.
// ----------------------------------------------------------------------------
package dcsb_pkg;

  localparam int TIMER_WIDTH_DEFAULT = 16;
  localparam int CFG_W               = 16;
  localparam int APB_DATA_W          = 32;
  localparam int APB_ADDR_W          = 4;

  // Register indexes (byte address = 4 * index).
  localparam logic [1:0] REG_DEBOUNCE     = 2'd0;
  localparam logic [1:0] REG_CLICK_WINDOW = 2'd1;
  localparam logic [1:0] REG_DOT          = 2'd2;
  localparam logic [1:0] REG_DASH         = 2'd3;

  localparam logic [CFG_W-1:0] DEBOUNCE_RESET     = 16'd50;
  localparam logic [CFG_W-1:0] CLICK_WINDOW_RESET = 16'd1500;
  localparam logic [CFG_W-1:0] DOT_RESET          = 16'd200;
  localparam logic [CFG_W-1:0] DASH_RESET         = 16'd500;

  // SOS is nine elements; elements three to five are dashes.
  localparam logic [3:0] SOS_ELEMENTS = 4'd9;
  localparam logic [3:0] DASH_FIRST   = 4'd3;
  localparam logic [3:0] DASH_LAST    = 4'd5;
  localparam logic [1:0] DOUBLE_CLICK = 2'd2;

  typedef enum logic [3:0] {
    MODE_IDLE = 4'b0001,
    MODE_HOLD = 4'b0010,
    MODE_SOS  = 4'b0100,
    MODE_WAIT = 4'b1000
  } mode_t;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_ticks;
    logic [CFG_W-1:0] click_window_ticks;
    logic [CFG_W-1:0] dot_ticks;
    logic [CFG_W-1:0] dash_ticks;
  } cfg_t;

  typedef struct packed {
    mode_t      mode;
    logic [1:0] press_count;
    logic [3:0] element_index;
    logic       lit_phase;
    logic       previous_level;
  } ctrl_t;

  typedef struct packed {
    logic led_on;
    logic press_seen;
    logic sos_busy;
  } result_t;

endpackage

>>> design/double_click_sos_beacon_top.sv
// ----------------------------------------------------------------------------
// double_click_sos_beacon_top: double-click detector with Morse SOS output
// Button ticks in, one LED/press/busy word out per tick, APB register port.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one button sample per timer
//   tick, active low. Output channel (out_valid / out_stall) returns exactly
//   one word per accepted sample: led_on, press_seen and sos_busy as they
//   stand after that tick.
//   The word for a sample is presented the cycle after it is accepted.
//   A sample can be accepted every cycle unless the receiver stalls, since
//   all work for a tick is one step-logic pass into the result register.
//   When the receiver stalls, the result register holds its word and
//   in_stall rises in the same cycle, so no sample is taken until the word
//   is drained; a sample arriving in the cycle the word is taken is accepted.
//   The APB port holds the four timing registers (debounce, click window,
//   dot, dash) at byte addresses 0, 4, 8 and 12; write them only while idle.
//   Reset (rst, synchronous) empties the result register, returns the
//   detector to idle with the button seen as released and loads the
//   registers with their defaults.
module double_click_sos_beacon_top #(
  parameter int TIMER_WIDTH = dcsb_pkg::TIMER_WIDTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            button_level,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            led_on,
  output logic                            press_seen,
  output logic                            sos_busy,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [dcsb_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [dcsb_pkg::APB_DATA_W-1:0] pwdata,
  output logic [dcsb_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);
  import dcsb_pkg::*;

  cfg_t                   cfg;
  ctrl_t                  ctrl;
  ctrl_t                  ctrl_next;
  logic [TIMER_WIDTH-1:0] hold_timer;
  logic [TIMER_WIDTH-1:0] hold_timer_next;
  logic [TIMER_WIDTH-1:0] since_last_press;
  logic [TIMER_WIDTH-1:0] since_last_press_next;
  result_t                res;
  logic                   in_take;
  logic                   cfg_write;
  logic [1:0]             reg_index;

  assign pready    = 1'b1;
  assign reg_index = paddr[3:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks     <= DEBOUNCE_RESET;
      cfg.click_window_ticks <= CLICK_WINDOW_RESET;
      cfg.dot_ticks          <= DOT_RESET;
      cfg.dash_ticks         <= DASH_RESET;
    end else if (cfg_write) begin
      unique case (reg_index)
        REG_DEBOUNCE:     cfg.debounce_ticks     <= pwdata[CFG_W-1:0];
        REG_CLICK_WINDOW: cfg.click_window_ticks <= pwdata[CFG_W-1:0];
        REG_DOT:          cfg.dot_ticks          <= pwdata[CFG_W-1:0];
        REG_DASH:         cfg.dash_ticks         <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_DEBOUNCE:     prdata = APB_DATA_W'(cfg.debounce_ticks);
      REG_CLICK_WINDOW: prdata = APB_DATA_W'(cfg.click_window_ticks);
      REG_DOT:          prdata = APB_DATA_W'(cfg.dot_ticks);
      REG_DASH:         prdata = APB_DATA_W'(cfg.dash_ticks);
      default:          prdata = '0;
    endcase
  end

  // The result register is free when empty or being drained this cycle.
  assign in_stall = out_valid && out_stall;
  assign in_take  = in_valid && !in_stall;

  dcsb_step #(
    .TIMER_WIDTH(TIMER_WIDTH)
  ) u_step (
    .level                 (button_level),
    .cfg                   (cfg),
    .ctrl                  (ctrl),
    .hold_timer            (hold_timer),
    .since_last_press      (since_last_press),
    .ctrl_next             (ctrl_next),
    .hold_timer_next       (hold_timer_next),
    .since_last_press_next (since_last_press_next),
    .res                   (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl.mode           <= MODE_IDLE;
      ctrl.press_count    <= 2'd0;
      ctrl.element_index  <= 4'd0;
      ctrl.lit_phase      <= 1'b0;
      ctrl.previous_level <= 1'b1;
      hold_timer          <= '0;
      since_last_press    <= '0;
      out_valid           <= 1'b0;
    end else begin
      if (in_take) begin
        ctrl             <= ctrl_next;
        hold_timer       <= hold_timer_next;
        since_last_press <= since_last_press_next;
        out_valid        <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      led_on     <= res.led_on;
      press_seen <= res.press_seen;
      sos_busy   <= res.sos_busy;
    end
  end

endmodule

>>> design/dcsb_step.sv
// ----------------------------------------------------------------------------
// dcsb_step: next-state logic for one button tick
// Debounce, click counting and SOS sequencing for one sample, purely
// combinational between the state registers and the result register.
// ----------------------------------------------------------------------------
module dcsb_step #(
  parameter int TIMER_WIDTH = dcsb_pkg::TIMER_WIDTH_DEFAULT
) (
  input  logic                   level,
  input  dcsb_pkg::cfg_t         cfg,
  input  dcsb_pkg::ctrl_t        ctrl,
  input  logic [TIMER_WIDTH-1:0] hold_timer,
  input  logic [TIMER_WIDTH-1:0] since_last_press,
  output dcsb_pkg::ctrl_t        ctrl_next,
  output logic [TIMER_WIDTH-1:0] hold_timer_next,
  output logic [TIMER_WIDTH-1:0] since_last_press_next,
  output dcsb_pkg::result_t      res
);
  import dcsb_pkg::*;

  localparam int WideW = (TIMER_WIDTH > CFG_W) ? TIMER_WIDTH : CFG_W;
  localparam logic [TIMER_WIDTH-1:0] TimerMax = '1;
  localparam logic [TIMER_WIDTH-1:0] TimerOne = TIMER_WIDTH'(1);

  // A zero length acts as one; a length beyond the timer saturates.
  function automatic logic [TIMER_WIDTH-1:0] load_length(input logic [CFG_W-1:0] v);
    logic [WideW-1:0] w;
    w = WideW'(v);
    if (v == '0) begin
      return TimerOne;
    end else if (w > WideW'(TimerMax)) begin
      return TimerMax;
    end else begin
      return TIMER_WIDTH'(w);
    end
  endfunction

  function automatic logic [TIMER_WIDTH-1:0] element_length(input logic [3:0] idx,
                                                            input cfg_t c);
    if (idx >= DASH_FIRST && idx <= DASH_LAST) begin
      return load_length(c.dash_ticks);
    end else begin
      return load_length(c.dot_ticks);
    end
  endfunction

  logic [TIMER_WIDTH-1:0] since_inc;
  logic                   timer_done;
  logic [1:0]             count_inc;
  logic [3:0]             index_inc;

  assign since_inc  = (since_last_press == TimerMax) ? since_last_press
                                                     : since_last_press + TimerOne;
  assign timer_done = (hold_timer <= TimerOne);
  assign count_inc  = (WideW'(since_inc) < WideW'(cfg.click_window_ticks))
                      ? ctrl.press_count + 2'd1 : 2'd1;
  assign index_inc  = ctrl.element_index + 4'd1;

  always_comb begin
    ctrl_next             = ctrl;
    hold_timer_next       = hold_timer;
    since_last_press_next = since_inc;
    res.press_seen        = 1'b0;

    unique case (ctrl.mode)
      MODE_IDLE: begin
        if (!level && ctrl.previous_level) begin
          ctrl_next.mode  = MODE_HOLD;
          hold_timer_next = load_length(cfg.debounce_ticks);
        end
        ctrl_next.previous_level = level;
      end
      MODE_HOLD: begin
        if (timer_done) begin
          hold_timer_next = '0;
          if (!level) begin
            res.press_seen        = 1'b1;
            since_last_press_next = '0;
            if (count_inc == DOUBLE_CLICK) begin
              ctrl_next.press_count   = 2'd0;
              ctrl_next.mode          = MODE_SOS;
              ctrl_next.element_index = 4'd0;
              ctrl_next.lit_phase     = 1'b1;
              hold_timer_next         = element_length(4'd0, cfg);
            end else begin
              ctrl_next.press_count = count_inc;
              ctrl_next.mode        = MODE_WAIT;
            end
          end else begin
            ctrl_next.mode = MODE_IDLE;
          end
        end else begin
          hold_timer_next = hold_timer - TimerOne;
        end
      end
      MODE_SOS: begin
        if (timer_done) begin
          if (ctrl.lit_phase) begin
            ctrl_next.lit_phase = 1'b0;
            hold_timer_next     = element_length(ctrl.element_index, cfg);
          end else if (index_inc >= SOS_ELEMENTS) begin
            ctrl_next.element_index = 4'd0;
            hold_timer_next         = '0;
            ctrl_next.mode          = MODE_WAIT;
          end else begin
            ctrl_next.element_index = index_inc;
            ctrl_next.lit_phase     = 1'b1;
            hold_timer_next         = element_length(index_inc, cfg);
          end
        end else begin
          hold_timer_next = hold_timer - TimerOne;
        end
      end
      MODE_WAIT: begin
        if (level) begin
          ctrl_next.mode           = MODE_IDLE;
          ctrl_next.previous_level = 1'b1;
        end
      end
      default: begin
        ctrl_next.mode = MODE_IDLE;
      end
    endcase

    res.sos_busy = (ctrl_next.mode == MODE_SOS);
    res.led_on   = (ctrl_next.mode == MODE_SOS) && ctrl_next.lit_phase;
  end

endmodule

>>> design/dcsb_checker.sv
// ----------------------------------------------------------------------------
// dcsb_checker: port-level checks for the double-click SOS beacon
// Watches the channels of the top level and is bound to it below.
// ----------------------------------------------------------------------------
module dcsb_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic led_on,
  input logic press_seen,
  input logic sos_busy
);

  // The result register is empty right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("word present after reset");

  // Every accepted sample produces a word in the next cycle.
  a_item_to_word: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted sample produced no word");

  // A held word blocks the input side.
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> in_stall)
    else $error("sample taken while word is stalled");

  // The LED can only be lit while SOS plays.
  a_led_in_sos: assert property (@(posedge clk) disable iff (rst)
    (out_valid && led_on) |-> sos_busy)
    else $error("LED lit outside SOS");

  // A stalled word keeps its value.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable(led_on) && $stable(press_seen) && $stable(sos_busy)))
    else $error("stalled word changed");

endmodule

bind double_click_sos_beacon_top dcsb_checker u_dcsb_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .led_on     (led_on),
  .press_seen (press_seen),
  .sos_busy   (sos_busy)
);
